/* rtl/core/eta_pkg.sv */
// ----------------------------------------------------------------------------
// eta_pkg
// Shared types and constants for the environment threshold alert block.
// ----------------------------------------------------------------------------
package eta_pkg;

    typedef enum logic [2:0] {
        AL_NONE       = 3'd0,
        AL_TEMP_LOW   = 3'd1,
        AL_TEMP_HIGH  = 3'd2,
        AL_HUMID_LOW  = 3'd3,
        AL_HUMID_HIGH = 3'd4,
        AL_LIGHT_LOW  = 3'd5,
        AL_LIGHT_HIGH = 3'd6
    } t_alert;

    typedef enum logic [2:0] {
        CFG_TEMP_LOW   = 3'd0,
        CFG_TEMP_HIGH  = 3'd1,
        CFG_HUMID_LOW  = 3'd2,
        CFG_HUMID_HIGH = 3'd3,
        CFG_LIGHT_LOW  = 3'd4,
        CFG_LIGHT_HIGH = 3'd5,
        CFG_ALERT_EN   = 3'd6,
        CFG_VOICE_EN   = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TS_W       = 32;

    localparam int DEF_REPEAT_INTERVAL_MS = 60000;
    localparam int DEF_TIME_BITS          = 32;

    localparam logic signed [7:0] RST_TEMP_LOW   = 8'sd10;
    localparam logic signed [7:0] RST_TEMP_HIGH  = 8'sd30;
    localparam logic [6:0]        RST_HUMID_LOW  = 7'd30;
    localparam logic [6:0]        RST_HUMID_HIGH = 7'd70;
    localparam logic [15:0]       RST_LIGHT_LOW  = 16'd10;
    localparam logic [15:0]       RST_LIGHT_HIGH = 16'd10000;

    typedef struct packed {
        logic signed [7:0] temp_min;
        logic signed [7:0] temp_max;
        logic [6:0]        humid_low;
        logic [6:0]        humid_high;
        logic [15:0]       lux_min;
        logic [15:0]       lux_max;
        logic              alert_en;
        logic              voice_en;
    } t_cfg;

    // lowest member last: matches tdata packing
    typedef struct packed {
        logic [TS_W-1:0]    time_ms;
        logic [19:0]        illuminance;
        logic               light_valid;
        logic [9:0]         humidity;
        logic signed [11:0] temperature;
        logic               climate_valid;
        logic               snapshot_ok;
    } t_item;

    typedef struct packed {
        logic   play_voice;
        logic   announce;
        t_alert active_alert;
    } t_result;

    localparam int ITEM_W     = $bits(t_item);
    localparam int RESULT_W   = $bits(t_result);
    localparam int IN_DATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

/* rtl/core/eta_classify.sv */
// ----------------------------------------------------------------------------
// eta_classify
// Fixed-priority threshold classifier for one registered sample.
// ----------------------------------------------------------------------------
module eta_classify (
    input  eta_pkg::t_cfg   i_cfg,
    input  eta_pkg::t_item  i_item,
    output eta_pkg::t_alert o_alert
);

    logic signed [12:0] w_tl10;
    logic signed [12:0] w_th10;
    logic signed [12:0] w_temp;
    logic [10:0]        w_hl10;
    logic [10:0]        w_hh10;
    logic [10:0]        w_humid;
    logic [19:0]        w_ll10;
    logic [19:0]        w_lh10;

    // limits are whole units, readings are tenths
    assign w_tl10  = 13'(i_cfg.temp_min) * 13'sd10;
    assign w_th10  = 13'(i_cfg.temp_max) * 13'sd10;
    assign w_temp  = 13'(i_item.temperature);
    assign w_hl10  = 11'(i_cfg.humid_low) * 11'd10;
    assign w_hh10  = 11'(i_cfg.humid_high) * 11'd10;
    assign w_humid = 11'(i_item.humidity);
    assign w_ll10  = 20'(i_cfg.lux_min) * 20'd10;
    assign w_lh10  = 20'(i_cfg.lux_max) * 20'd10;

    always_comb begin
        o_alert = eta_pkg::AL_NONE;
        if (i_cfg.alert_en && i_item.snapshot_ok) begin
            if (i_item.climate_valid && (w_temp < w_tl10)) begin
                o_alert = eta_pkg::AL_TEMP_LOW;
            end else if (i_item.climate_valid && (w_temp > w_th10)) begin
                o_alert = eta_pkg::AL_TEMP_HIGH;
            end else if (i_item.climate_valid && (w_humid < w_hl10)) begin
                o_alert = eta_pkg::AL_HUMID_LOW;
            end else if (i_item.climate_valid && (w_humid > w_hh10)) begin
                o_alert = eta_pkg::AL_HUMID_HIGH;
            end else if (i_item.light_valid && (i_item.illuminance < w_ll10)) begin
                o_alert = eta_pkg::AL_LIGHT_LOW;
            end else if (i_item.light_valid && (i_item.illuminance > w_lh10)) begin
                o_alert = eta_pkg::AL_LIGHT_HIGH;
            end
        end
    end

endmodule

/* rtl/core/eta_tracker.sv */
// ----------------------------------------------------------------------------
// eta_tracker
// Holds the active alert and last announcement time, decides announcements
// and owns the result register.
// ----------------------------------------------------------------------------
module eta_tracker #(
    parameter int REPEAT_INTERVAL_MS = eta_pkg::DEF_REPEAT_INTERVAL_MS,
    parameter int TIME_BITS          = eta_pkg::DEF_TIME_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_move,
    input  logic                      i_out_ready,
    input  eta_pkg::t_alert           i_alert,
    input  logic [eta_pkg::TS_W-1:0]  i_time_ms,
    input  logic                      i_voice_en,
    output logic                      o_out_valid,
    output eta_pkg::t_result          o_result
);

    eta_pkg::t_alert  r_cur;
    eta_pkg::t_alert  n_cur;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] n_last;
    logic                 r_out_valid;
    logic                 n_out_valid;
    eta_pkg::t_result     r_result;
    eta_pkg::t_result     n_result;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_due;
    logic                 w_announce;

    assign w_now      = TIME_BITS'(i_time_ms);
    assign w_elapsed  = w_now - r_last;
    assign w_due      = w_elapsed >= TIME_BITS'(REPEAT_INTERVAL_MS);
    assign w_announce = (i_alert != eta_pkg::AL_NONE) && ((i_alert != r_cur) || w_due);

    always_comb begin
        n_cur  = r_cur;
        n_last = r_last;
        if (i_alert == eta_pkg::AL_NONE) begin
            n_cur = eta_pkg::AL_NONE;
        end else if (w_announce) begin
            n_cur  = i_alert;
            n_last = w_now;
        end
        n_result.active_alert = n_cur;
        n_result.announce     = w_announce;
        n_result.play_voice   = w_announce && i_voice_en;
        n_out_valid = i_move || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= eta_pkg::AL_NONE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_move) begin
                r_cur  <= n_cur;
                r_last <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

/* rtl/core/environment_threshold_alert.sv */
// ----------------------------------------------------------------------------
// environment_threshold_alert
// Classifies environment samples against thresholds and paces announcements.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one sensor sample per request; m_axis_* returns one
//   result per sample (active alert, announce, play_voice) in order.
//   i_cfg_* writes the threshold and enable registers, one per cycle; the
//   user must do this only while the block is idle; the block has no check.
// Path: an accepted sample is held in the input register, is classified and
//   lands in the result register once that register is free or draining,
//   and is then offered on m_axis.
// Throughput: one sample per cycle while results drain; the input register
//   and result register form a two-deep pipe, and the alert/timestamp state
//   updates in the same cycle a sample moves into the result register.
// Stall: while a result waits on m_axis_tready, one more sample is held in
//   the input register; s_axis_tready drops only when both are full.
// Reset: synchronous, active low; clears both registers' valid flags, the
//   held alert, the last announcement time and loads default thresholds
//   with alerts and voice disabled.
// ----------------------------------------------------------------------------
module environment_threshold_alert #(
    parameter int REPEAT_INTERVAL_MS = eta_pkg::DEF_REPEAT_INTERVAL_MS,
    parameter int TIME_BITS          = eta_pkg::DEF_TIME_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // snapshot_ok, climate_valid, temperature[12], humidity[10],
    // light_valid, illuminance[20], time_ms[32], zero pad
    input  logic [eta_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // active_alert[3], announce, play_voice, zero pad
    output logic [eta_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [eta_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [eta_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    eta_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    eta_pkg::t_item   r_item;
    eta_pkg::t_alert  w_alert;
    eta_pkg::t_result w_result;
    logic             w_out_valid;
    logic             w_move;
    logic             w_in_req;

    assign w_move        = r_in_valid && (!w_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_move;
    assign w_in_req      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_cfg.temp_min   <= eta_pkg::RST_TEMP_LOW;
            r_cfg.temp_max   <= eta_pkg::RST_TEMP_HIGH;
            r_cfg.humid_low  <= eta_pkg::RST_HUMID_LOW;
            r_cfg.humid_high <= eta_pkg::RST_HUMID_HIGH;
            r_cfg.lux_min    <= eta_pkg::RST_LIGHT_LOW;
            r_cfg.lux_max    <= eta_pkg::RST_LIGHT_HIGH;
            r_cfg.alert_en   <= 1'b0;
            r_cfg.voice_en   <= 1'b0;
        end else begin
            r_in_valid <= w_in_req || (r_in_valid && !w_move);
            if (i_cfg_we) begin
                unique case (eta_pkg::t_cfg_idx'(i_cfg_idx))
                    eta_pkg::CFG_TEMP_LOW:   r_cfg.temp_min   <= i_cfg_data[7:0];
                    eta_pkg::CFG_TEMP_HIGH:  r_cfg.temp_max   <= i_cfg_data[7:0];
                    eta_pkg::CFG_HUMID_LOW:  r_cfg.humid_low  <= i_cfg_data[6:0];
                    eta_pkg::CFG_HUMID_HIGH: r_cfg.humid_high <= i_cfg_data[6:0];
                    eta_pkg::CFG_LIGHT_LOW:  r_cfg.lux_min    <= i_cfg_data;
                    eta_pkg::CFG_LIGHT_HIGH: r_cfg.lux_max    <= i_cfg_data;
                    eta_pkg::CFG_ALERT_EN:   r_cfg.alert_en   <= i_cfg_data[0];
                    eta_pkg::CFG_VOICE_EN:   r_cfg.voice_en   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_item <= eta_pkg::t_item'(s_axis_tdata[eta_pkg::ITEM_W-1:0]);
        end
    end

    eta_classify u_classify (
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .o_alert (w_alert)
    );

    eta_tracker #(
        .REPEAT_INTERVAL_MS (REPEAT_INTERVAL_MS),
        .TIME_BITS          (TIME_BITS)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_move      (w_move),
        .i_out_ready (m_axis_tready),
        .i_alert     (w_alert),
        .i_time_ms   (r_item.time_ms),
        .i_voice_en  (r_cfg.voice_en),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = eta_pkg::OUT_DATA_W'(w_result);

    a_voice_needs_announce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_result.play_voice) |-> w_result.announce)
        else $error("play_voice without announce");

    a_announce_has_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_result.announce) |-> (w_result.active_alert != eta_pkg::AL_NONE))
        else $error("announce with no active alert");

    a_stall_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output side can drain");

endmodule

/* test/tb_environment_threshold_alert.sv */
// ----------------------------------------------------------------------------
// tb_environment_threshold_alert
// Streams environment samples into the alert block under random idle and
// back-pressure, predicts each result (held alert, announce, voice) from a
// local model of the thresholds and the repeat timer, or takes it from a short
// directed table run before random setups, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_environment_threshold_alert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 8;
    localparam int PHASE_SAMPLES   = 166;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int REPEAT_MS       = eta_pkg::DEF_REPEAT_INTERVAL_MS;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [eta_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [eta_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           i_cfg_we;
    logic [eta_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [eta_pkg::CFG_DATA_W-1:0] i_cfg_data;

    environment_threshold_alert u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        bit                your_write;
        eta_pkg::t_cfg_idx reg_idx;
        logic [15:0]       reg_val;
        eta_pkg::t_item    smp;
        bit                typed;
        eta_pkg::t_result  want;
    } t_plan_row;

    t_plan_row        plan[$];
    eta_pkg::t_result pending_results[$];

    eta_pkg::t_cfg    limits;
    eta_pkg::t_alert  held_alert;
    logic [31:0]      last_announce_ms;

    logic [31:0]      clock_ms;
    eta_pkg::t_item   last_draw;
    bit               idle_on;
    bit               hold_request;
    bit               hold_served;

    int n_errors;
    int n_samples;
    int n_results;
    int n_announce;
    int n_voice;
    int n_stall_cycles;

    function automatic eta_pkg::t_item mk_sample(input logic snap, input logic cv,
                                                 input int temp, input int hum,
                                                 input logic lv, input int lux,
                                                 input logic [31:0] ms);
        eta_pkg::t_item s;
        s.snapshot_ok   = snap;
        s.climate_valid = cv;
        s.temperature   = temp[11:0];
        s.humidity      = hum[9:0];
        s.light_valid   = lv;
        s.illuminance   = lux[19:0];
        s.time_ms       = ms;
        return s;
    endfunction

    function automatic eta_pkg::t_result outcome(input eta_pkg::t_alert a, input logic ann,
                                                 input logic voice);
        eta_pkg::t_result r;
        r.active_alert = a;
        r.announce     = ann;
        r.play_voice   = voice;
        return r;
    endfunction

    function automatic void plan_write(input eta_pkg::t_cfg_idx idx, input logic [15:0] val);
        t_plan_row row;
        row.your_write = 1'b1;
        row.reg_idx    = idx;
        row.reg_val    = val;
        row.smp        = '0;
        row.typed      = 1'b0;
        row.want       = outcome(eta_pkg::AL_NONE, 1'b0, 1'b0);
        plan.push_back(row);
    endfunction

    function automatic void plan_sample(input eta_pkg::t_item smp, input bit typed,
                                        input eta_pkg::t_result want);
        t_plan_row row;
        row.your_write = 1'b0;
        row.reg_idx    = eta_pkg::CFG_TEMP_LOW;
        row.reg_val    = '0;
        row.smp        = smp;
        row.typed      = typed;
        row.want       = want;
        plan.push_back(row);
    endfunction

    // held alert and repeat timer, updated once per accepted sample
    function automatic eta_pkg::t_result predict_alert(input eta_pkg::t_item smp);
        eta_pkg::t_alert  seen;
        eta_pkg::t_result r;
        int               temp;
        int               t_lo;
        int               t_hi;
        logic [31:0]      elapsed;
        temp = $signed(smp.temperature);
        t_lo = $signed(limits.temp_min) * 10;
        t_hi = $signed(limits.temp_max) * 10;
        seen = eta_pkg::AL_NONE;
        if (limits.alert_en && smp.snapshot_ok) begin
            if (smp.climate_valid && temp < t_lo) begin
                seen = eta_pkg::AL_TEMP_LOW;
            end else if (smp.climate_valid && temp > t_hi) begin
                seen = eta_pkg::AL_TEMP_HIGH;
            end else if (smp.climate_valid &&
                         int'(smp.humidity) < int'(limits.humid_low) * 10) begin
                seen = eta_pkg::AL_HUMID_LOW;
            end else if (smp.climate_valid &&
                         int'(smp.humidity) > int'(limits.humid_high) * 10) begin
                seen = eta_pkg::AL_HUMID_HIGH;
            end else if (smp.light_valid &&
                         int'(smp.illuminance) < int'(limits.lux_min) * 10) begin
                seen = eta_pkg::AL_LIGHT_LOW;
            end else if (smp.light_valid &&
                         int'(smp.illuminance) > int'(limits.lux_max) * 10) begin
                seen = eta_pkg::AL_LIGHT_HIGH;
            end
        end
        r.announce   = 1'b0;
        r.play_voice = 1'b0;
        if (seen == eta_pkg::AL_NONE) begin
            held_alert = eta_pkg::AL_NONE;
        end else begin
            elapsed = smp.time_ms - last_announce_ms;
            if (seen != held_alert || elapsed >= REPEAT_MS) begin
                r.announce       = 1'b1;
                r.play_voice     = limits.voice_en;
                last_announce_ms = smp.time_ms;
                held_alert       = seen;
            end
        end
        r.active_alert = held_alert;
        return r;
    endfunction

    function automatic eta_pkg::t_item draw_sample();
        int             temp;
        int             hum;
        int             lux;
        logic           snap;
        logic           cv;
        logic           lv;
        eta_pkg::t_item s;
        if ($urandom_range(0, 1) == 1) begin
            s = last_draw;
        end else begin
            snap = $urandom_range(0, 15) != 0;
            cv   = $urandom_range(0, 7) != 0;
            lv   = $urandom_range(0, 7) != 0;
            case ($urandom_range(0, 3))
                0: temp = $urandom_range(0, 4095);
                1: temp = $signed(limits.temp_min) * 10 + int'($urandom_range(0, 20)) - 10;
                2: temp = $signed(limits.temp_max) * 10 + int'($urandom_range(0, 20)) - 10;
                default: temp = int'($urandom_range(0, 1650)) - 400;
            endcase
            case ($urandom_range(0, 3))
                0: hum = $urandom_range(0, 1023);
                1: hum = int'(limits.humid_low) * 10 + int'($urandom_range(0, 20)) - 10;
                2: hum = int'(limits.humid_high) * 10 + int'($urandom_range(0, 20)) - 10;
                default: hum = $urandom_range(0, 1000);
            endcase
            case ($urandom_range(0, 3))
                0: lux = $urandom_range(0, 1048575);
                1: lux = int'(limits.lux_min) * 10 + int'($urandom_range(0, 20)) - 10;
                2: lux = int'(limits.lux_max) * 10 + int'($urandom_range(0, 20)) - 10;
                default: lux = $urandom_range(0, 655350);
            endcase
            s = mk_sample(snap, cv, temp, hum, lv, lux, 32'd0);
        end
        case ($urandom_range(0, 15))
            0:       clock_ms = $urandom();
            1, 2:    clock_ms = clock_ms + $urandom_range(59990, 60010);
            3:       clock_ms = clock_ms + $urandom_range(0, 120000);
            default: clock_ms = clock_ms + $urandom_range(0, 3000);
        endcase
        s.time_ms = clock_ms;
        last_draw = s;
        return s;
    endfunction

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        i_cfg_we      <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_reg(input eta_pkg::t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            eta_pkg::CFG_TEMP_LOW:   limits.temp_min   = val[7:0];
            eta_pkg::CFG_TEMP_HIGH:  limits.temp_max   = val[7:0];
            eta_pkg::CFG_HUMID_LOW:  limits.humid_low  = val[6:0];
            eta_pkg::CFG_HUMID_HIGH: limits.humid_high = val[6:0];
            eta_pkg::CFG_LIGHT_LOW:  limits.lux_min    = val;
            eta_pkg::CFG_LIGHT_HIGH: limits.lux_max    = val;
            eta_pkg::CFG_ALERT_EN:   limits.alert_en   = val[0];
            eta_pkg::CFG_VOICE_EN:   limits.voice_en   = val[0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input eta_pkg::t_item smp, input bit typed,
                               input eta_pkg::t_result want);
        int               gap;
        eta_pkg::t_result model_res;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= eta_pkg::IN_DATA_W'(smp);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_res = predict_alert(smp);
        pending_results.push_back(typed ? want : model_res);
        n_samples++;
    endtask

    task automatic setup_phase(input int p);
        int          tl;
        int          th;
        int          hl;
        int          hh;
        int          ll;
        int          lh;
        logic        alert_bit;
        logic [15:0] noise;
        tl = int'($urandom_range(0, 80)) - 40;
        th = tl + int'($urandom_range(0, 60));
        if (th > 127) begin
            th = 127;
        end
        hl = $urandom_range(0, 60);
        hh = hl + int'($urandom_range(0, 67));
        ll = $urandom_range(0, 2000);
        lh = ll + int'($urandom_range(0, 30000));
        if ($urandom_range(0, 3) == 0) begin
            tl = $urandom_range(0, 255);
            th = $urandom_range(0, 255);
            hl = $urandom_range(0, 127);
            hh = $urandom_range(0, 127);
            ll = $urandom_range(0, 65535);
            lh = $urandom_range(0, 65535);
        end
        if (p == 1) begin
            tl = -128; th = 127; hl = 0; hh = 127; ll = 0; lh = 65535;
        end
        if (p == 2) begin
            tl = -40; th = 125; hl = 100; hh = 100; ll = 65535; lh = 65535;
        end
        alert_bit = (p != 5);
        wait_idle();
        noise = 16'($urandom());
        set_reg(eta_pkg::CFG_TEMP_LOW, {noise[7:0], tl[7:0]});
        noise = 16'($urandom());
        set_reg(eta_pkg::CFG_TEMP_HIGH, {noise[7:0], th[7:0]});
        noise = 16'($urandom());
        set_reg(eta_pkg::CFG_HUMID_LOW, {noise[8:0], hl[6:0]});
        noise = 16'($urandom());
        set_reg(eta_pkg::CFG_HUMID_HIGH, {noise[8:0], hh[6:0]});
        set_reg(eta_pkg::CFG_LIGHT_LOW, ll[15:0]);
        set_reg(eta_pkg::CFG_LIGHT_HIGH, lh[15:0]);
        noise = 16'($urandom());
        set_reg(eta_pkg::CFG_ALERT_EN, {noise[14:0], alert_bit});
        noise = 16'($urandom());
        set_reg(eta_pkg::CFG_VOICE_EN, noise);
    endtask

    function automatic void build_plan();
        // alerts are off out of reset
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'd100), 1,
                    outcome(eta_pkg::AL_NONE, 0, 0));
        plan_write(eta_pkg::CFG_ALERT_EN, 16'd1);
        plan_write(eta_pkg::CFG_VOICE_EN, 16'd1);
        // failed snapshot clears
        plan_sample(mk_sample(0, 1, -400, 500, 1, 5000, 32'd500), 1,
                    outcome(eta_pkg::AL_NONE, 0, 0));
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'd1000), 1,
                    outcome(eta_pkg::AL_TEMP_LOW, 1, 1));
        // held one tick short of the repeat, then due
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'd60999), 1,
                    outcome(eta_pkg::AL_TEMP_LOW, 0, 0));
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'd61000), 1,
                    outcome(eta_pkg::AL_TEMP_LOW, 1, 1));
        plan_sample(mk_sample(1, 1, 1250, 500, 1, 5000, 32'd61001), 1,
                    outcome(eta_pkg::AL_TEMP_HIGH, 1, 1));
        // readings equal to a limit do not trip it
        plan_sample(mk_sample(1, 1, 100, 0, 1, 5000, 32'd61002), 1,
                    outcome(eta_pkg::AL_HUMID_LOW, 1, 1));
        plan_sample(mk_sample(1, 1, 300, 1000, 1, 5000, 32'd61003), 1,
                    outcome(eta_pkg::AL_HUMID_HIGH, 1, 1));
        plan_sample(mk_sample(1, 0, -400, 0, 1, 0, 32'd61004), 1,
                    outcome(eta_pkg::AL_LIGHT_LOW, 1, 1));
        plan_sample(mk_sample(1, 0, -400, 0, 1, 655350, 32'd61005), 1,
                    outcome(eta_pkg::AL_LIGHT_HIGH, 1, 1));
        plan_sample(mk_sample(1, 0, 2047, 1023, 1, 1048575, 32'd61006), 0, '0);
        plan_sample(mk_sample(1, 1, 200, 500, 1, 100, 32'd61007), 1,
                    outcome(eta_pkg::AL_NONE, 0, 0));
        plan_sample(mk_sample(1, 0, -400, 0, 0, 0, 32'd61008), 1,
                    outcome(eta_pkg::AL_NONE, 0, 0));
        // repeat timer across the timestamp wrap
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'hFFFF_FFF0), 1,
                    outcome(eta_pkg::AL_TEMP_LOW, 1, 1));
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'd59983), 0, '0);
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'd59984), 0, '0);
        plan_write(eta_pkg::CFG_VOICE_EN, 16'd0);
        plan_sample(mk_sample(1, 1, 1250, 500, 1, 5000, 32'd60000), 1,
                    outcome(eta_pkg::AL_TEMP_HIGH, 1, 0));
        // widest legal limits
        plan_write(eta_pkg::CFG_TEMP_LOW, 16'h00D8);
        plan_write(eta_pkg::CFG_TEMP_HIGH, 16'd125);
        plan_write(eta_pkg::CFG_HUMID_LOW, 16'd0);
        plan_write(eta_pkg::CFG_HUMID_HIGH, 16'd100);
        plan_write(eta_pkg::CFG_LIGHT_LOW, 16'd0);
        plan_write(eta_pkg::CFG_LIGHT_HIGH, 16'hFFFF);
        plan_sample(mk_sample(1, 1, -400, 500, 1, 5000, 32'd70000), 0, '0);
        plan_sample(mk_sample(1, 1, -2048, 500, 1, 5000, 32'd70001), 0, '0);
        plan_sample(mk_sample(1, 1, 2047, 500, 1, 5000, 32'd70002), 0, '0);
        plan_sample(mk_sample(1, 1, 0, 1023, 1, 5000, 32'd70003), 0, '0);
        plan_sample(mk_sample(1, 1, 0, 500, 1, 1048575, 32'd70004), 0, '0);
        plan_sample(mk_sample(0, 1, -2048, 500, 1, 5000, 32'd70005), 0, '0);
        plan_write(eta_pkg::CFG_ALERT_EN, 16'd0);
        plan_sample(mk_sample(1, 1, -2048, 0, 1, 0, 32'd70006), 1,
                    outcome(eta_pkg::AL_NONE, 0, 0));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) begin
            n_stall_cycles++;
        end
    end

    initial begin : result_sink
        eta_pkg::t_result got;
        eta_pkg::t_result want;
        int               pause;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            pause = idle_on ? $urandom_range(0, 8) : 0;
            if (hold_request && !hold_served) begin
                pause       = HOLD_OFF_CYCLES;
                hold_served = 1'b1;
            end
            if (pause > 0) begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got = m_axis_tdata[eta_pkg::RESULT_W-1:0];
            n_results++;
            if (got.announce) n_announce++;
            if (got.play_voice) n_voice++;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with no request pending: alert %0d %0b %0b",
                         $time, got.active_alert, got.announce, got.play_voice);
            end else begin
                want = pending_results.pop_front();
                if (got.active_alert !== want.active_alert) begin
                    n_errors++;
                    $display("%0t: active_alert expected %0d, got %0d",
                             $time, want.active_alert, got.active_alert);
                end
                if (got.announce !== want.announce) begin
                    n_errors++;
                    $display("%0t: announce expected %0b, got %0b",
                             $time, want.announce, got.announce);
                end
                if (got.play_voice !== want.play_voice) begin
                    n_errors++;
                    $display("%0t: play_voice expected %0b, got %0b",
                             $time, want.play_voice, got.play_voice);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("** environment_threshold_alert: FAILED **");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = eta_pkg::CFG_TEMP_LOW;
        i_cfg_data    = '0;

        limits.temp_min   = eta_pkg::RST_TEMP_LOW;
        limits.temp_max   = eta_pkg::RST_TEMP_HIGH;
        limits.humid_low  = eta_pkg::RST_HUMID_LOW;
        limits.humid_high = eta_pkg::RST_HUMID_HIGH;
        limits.lux_min    = eta_pkg::RST_LIGHT_LOW;
        limits.lux_max    = eta_pkg::RST_LIGHT_HIGH;
        limits.alert_en   = 1'b0;
        limits.voice_en   = 1'b0;
        held_alert        = eta_pkg::AL_NONE;
        last_announce_ms  = '0;

        clock_ms     = '0;
        last_draw    = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        hold_served  = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_plan();
        foreach (plan[i]) begin
            if (plan[i].your_write) begin
                wait_idle();
                set_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_sample(plan[i].smp, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p % 3) != 2;
            setup_phase(p);
            if (p == 3) begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < PHASE_SAMPLES; k++) begin
                send_sample(draw_sample(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d samples over %0d threshold setups: %0d results,",
                 n_samples, PHASES + 3, n_results);
        $display("%0d announced, %0d voiced, input stalled %0d cycles, %0d mismatches.",
                 n_announce, n_voice, n_stall_cycles, n_errors);
        if (n_errors == 0) begin
            $display("** environment_threshold_alert: PASSED **");
        end else begin
            $display("** environment_threshold_alert: FAILED **");
        end
        $finish;
    end

endmodule

/* environment_threshold_alert.f */
rtl/core/eta_pkg.sv
rtl/core/eta_classify.sv
rtl/core/eta_tracker.sv
rtl/core/environment_threshold_alert.sv
test/tb_environment_threshold_alert.sv
